/* rtl/core/dfc_pkg.sv */
package dfc_pkg;

  localparam logic [1:0] CMD_RESTART = 2'd0;
  localparam logic [1:0] CMD_STEP    = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [1:0] CELL_PASSAGE = 2'd0;
  localparam logic [1:0] CELL_WALL    = 2'd1;
  localparam logic [1:0] CELL_START   = 2'd2;
  localparam logic [1:0] CELL_END     = 2'd3;

  localparam logic [1:0] DIR_EAST  = 2'd0;
  localparam logic [1:0] DIR_SOUTH = 2'd1;
  localparam logic [1:0] DIR_WEST  = 2'd2;
  localparam logic [1:0] DIR_NORTH = 2'd3;

  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  localparam int MIN_SIDE   = 3;
  localparam int SIZE_W     = 7;
  localparam int FIELD_W    = 6;
  localparam int ORDER_W    = 8;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // try order per order code, first direction in the top bits; codes 24..31 wrap
  localparam logic [ORDER_W-1:0] ORDER_TABLE [32] = '{
    8'h1B, 8'h1E, 8'h27, 8'h2D, 8'h36, 8'h39, 8'h4B, 8'h4E,
    8'h63, 8'h6C, 8'h72, 8'h78, 8'h87, 8'h8D, 8'h93, 8'h9C,
    8'hB1, 8'hB4, 8'hC6, 8'hC9, 8'hD2, 8'hD8, 8'hE1, 8'hE4,
    8'h1B, 8'h1E, 8'h27, 8'h2D, 8'h36, 8'h39, 8'h4B, 8'h4E
  };

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_START,
    ST_IDLE,
    ST_READ,
    ST_PROBE,
    ST_CHECK,
    ST_CARVE,
    ST_POP
  } state_t;

  typedef struct packed {
    logic en;
    logic we;
  } mem_ctl_t;

  typedef struct packed {
    logic               valid;
    logic [1:0]         cell_code;
    logic               carved;
    logic               gen_done;
    logic [FIELD_W-1:0] head_row;
    logic [FIELD_W-1:0] head_col;
  } result_t;

endpackage

/* rtl/core/dfc_ram.sv */
module dfc_ram #(
  parameter int DATA_W = 2,
  parameter int DEPTH  = 4096
) (
  input  logic                     clk,
  input  dfc_pkg::mem_ctl_t        ctl,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [DATA_W-1:0]        wdata,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

/* rtl/core/dfc_ctrl.sv */
module dfc_ctrl #(
  parameter int MAX_SIDE    = 64,
  parameter int STACK_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_command,
  input  logic [4:0]                    in_order_code,
  input  logic [dfc_pkg::FIELD_W-1:0]   in_cell_row,
  input  logic [dfc_pkg::FIELD_W-1:0]   in_cell_col,
  input  logic [dfc_pkg::SIZE_W-1:0]    grid_width,
  input  logic [dfc_pkg::SIZE_W-1:0]    grid_height,
  output dfc_pkg::result_t              result
);

  localparam int CW         = $clog2(MAX_SIDE);
  localparam int SW         = $clog2(MAX_SIDE + 1);
  localparam int TW         = CW + 2;
  localparam int CMPW       = (SW > dfc_pkg::SIZE_W) ? SW : dfc_pkg::SIZE_W;
  localparam int GRID_DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW         = $clog2(GRID_DEPTH);
  localparam int KW         = $clog2(STACK_DEPTH);
  localparam int NW         = $clog2(STACK_DEPTH + 1);
  localparam int SDW        = 2 * CW;
  localparam logic signed [TW-1:0] ONE = TW'(1);
  localparam logic signed [TW-1:0] TWO = TW'(2);

  dfc_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic            restart_r, restart_nxt;
  logic [NW-1:0]   count_r, count_nxt;
  logic            done_r, done_nxt;
  logic [1:0]      try_r, try_nxt;
  logic [dfc_pkg::ORDER_W-1:0] order_r, order_nxt;
  logic [CW-1:0]   head_row_r, head_row_nxt;
  logic [CW-1:0]   head_col_r, head_col_nxt;
  logic            res_valid_r, res_valid_nxt;
  dfc_pkg::result_t res_data_r, res_data_nxt;

  dfc_pkg::mem_ctl_t g_ctl;
  logic [AW-1:0]     g_addr;
  logic [1:0]        g_wdata;
  logic [1:0]        g_rdata;
  dfc_pkg::mem_ctl_t s_ctl;
  logic [KW-1:0]     s_addr;
  logic [SDW-1:0]    s_wdata;
  logic [SDW-1:0]    s_rdata;

  logic [CMPW-1:0] w_ext, h_ext;
  logic [SW-1:0]   w_cl, h_cl;
  logic [1:0]      dir;
  logic signed [TW-1:0] hr, hc, tr, tc, mr, mc, w_lim, h_lim;
  logic [CW-1:0]   tgt_row, tgt_col, mid_row, mid_col;
  logic            tgt_ok, full, probe_ok, last_try, read_in;
  logic            pop_go, res_fire;
  logic [1:0]      res_code;

  function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] rr, input logic [CW-1:0] cc);
    logic [AW-1:0] a;
    a = AW'(rr) * AW'(MAX_SIDE) + AW'(cc);
    return a;
  endfunction

  dfc_ram #(.DATA_W(2), .DEPTH(GRID_DEPTH)) u_grid (
    .clk   (clk),
    .ctl   (g_ctl),
    .addr  (g_addr),
    .wdata (g_wdata),
    .rdata (g_rdata)
  );

  dfc_ram #(.DATA_W(SDW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .ctl   (s_ctl),
    .addr  (s_addr),
    .wdata (s_wdata),
    .rdata (s_rdata)
  );

  // size saturation and neighbor geometry
  always_comb begin
    w_ext = CMPW'(grid_width);
    h_ext = CMPW'(grid_height);
    if (w_ext < CMPW'(dfc_pkg::MIN_SIDE)) begin
      w_cl = SW'(dfc_pkg::MIN_SIDE);
    end else if (w_ext > CMPW'(MAX_SIDE)) begin
      w_cl = SW'(MAX_SIDE);
    end else begin
      w_cl = SW'(w_ext);
    end
    if (h_ext < CMPW'(dfc_pkg::MIN_SIDE)) begin
      h_cl = SW'(dfc_pkg::MIN_SIDE);
    end else if (h_ext > CMPW'(MAX_SIDE)) begin
      h_cl = SW'(MAX_SIDE);
    end else begin
      h_cl = SW'(h_ext);
    end

    case (try_r)
      2'd0:    dir = order_r[7:6];
      2'd1:    dir = order_r[5:4];
      2'd2:    dir = order_r[3:2];
      default: dir = order_r[1:0];
    endcase

    hr = $signed(TW'(head_row_r));
    hc = $signed(TW'(head_col_r));
    tr = hr;
    tc = hc;
    mr = hr;
    mc = hc;
    case (dir)
      dfc_pkg::DIR_EAST: begin
        tc = hc + TWO;
        mc = hc + ONE;
      end
      dfc_pkg::DIR_SOUTH: begin
        tr = hr + TWO;
        mr = hr + ONE;
      end
      dfc_pkg::DIR_WEST: begin
        tc = hc - TWO;
        mc = hc - ONE;
      end
      default: begin
        tr = hr - TWO;
        mr = hr - ONE;
      end
    endcase

    w_lim   = $signed(TW'(w_cl));
    h_lim   = $signed(TW'(h_cl));
    tgt_ok  = !tr[TW-1] && (tr < h_lim) && !tc[TW-1] && (tc < w_lim);
    tgt_row = CW'(tr);
    tgt_col = CW'(tc);
    mid_row = CW'(mr);
    mid_col = CW'(mc);

    full     = (count_r == NW'(STACK_DEPTH));
    probe_ok = tgt_ok && !full;
    last_try = (try_r == 2'd3);
    read_in  = (CMPW'(in_cell_row) < CMPW'(MAX_SIDE)) && (CMPW'(in_cell_col) < CMPW'(MAX_SIDE));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dfc_pkg::ST_CLEAR: begin
        if (clr_addr_r == AW'(GRID_DEPTH - 1)) begin
          state_nxt = restart_r ? dfc_pkg::ST_START : dfc_pkg::ST_IDLE;
        end
      end
      dfc_pkg::ST_START: state_nxt = dfc_pkg::ST_IDLE;
      dfc_pkg::ST_IDLE: begin
        if (start) begin
          case (in_command)
            dfc_pkg::CMD_RESTART: state_nxt = dfc_pkg::ST_CLEAR;
            dfc_pkg::CMD_STEP:    state_nxt = done_r ? dfc_pkg::ST_IDLE : dfc_pkg::ST_PROBE;
            dfc_pkg::CMD_READ:    state_nxt = read_in ? dfc_pkg::ST_READ : dfc_pkg::ST_IDLE;
            default:              state_nxt = dfc_pkg::ST_IDLE;
          endcase
        end
      end
      dfc_pkg::ST_READ: state_nxt = dfc_pkg::ST_IDLE;
      dfc_pkg::ST_PROBE: begin
        if (probe_ok) begin
          state_nxt = dfc_pkg::ST_CHECK;
        end else if (last_try) begin
          state_nxt = (count_r == NW'(1)) ? dfc_pkg::ST_IDLE : dfc_pkg::ST_POP;
        end
      end
      dfc_pkg::ST_CHECK: begin
        if (g_rdata == dfc_pkg::CELL_WALL) begin
          state_nxt = dfc_pkg::ST_CARVE;
        end else if (last_try) begin
          state_nxt = (count_r == NW'(1)) ? dfc_pkg::ST_IDLE : dfc_pkg::ST_POP;
        end else begin
          state_nxt = dfc_pkg::ST_PROBE;
        end
      end
      dfc_pkg::ST_CARVE: state_nxt = dfc_pkg::ST_IDLE;
      dfc_pkg::ST_POP:   state_nxt = dfc_pkg::ST_IDLE;
      default:           state_nxt = dfc_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    clr_addr_nxt = clr_addr_r;
    restart_nxt  = restart_r;
    count_nxt    = count_r;
    done_nxt     = done_r;
    try_nxt      = try_r;
    order_nxt    = order_r;
    head_row_nxt = head_row_r;
    head_col_nxt = head_col_r;
    g_ctl        = '0;
    g_addr       = cell_addr(tgt_row, tgt_col);
    g_wdata      = dfc_pkg::CELL_PASSAGE;
    s_ctl        = '0;
    s_addr       = count_r[KW-1:0];
    s_wdata      = {tgt_row, tgt_col};
    pop_go       = 1'b0;
    res_fire     = 1'b0;
    res_code     = dfc_pkg::CELL_PASSAGE;

    case (state_r)
      dfc_pkg::ST_CLEAR: begin
        g_ctl        = '{en: 1'b1, we: 1'b1};
        g_addr       = clr_addr_r;
        g_wdata      = dfc_pkg::CELL_WALL;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      dfc_pkg::ST_START: begin
        g_ctl        = '{en: 1'b1, we: 1'b1};
        g_addr       = cell_addr(CW'(1), CW'(1));
        g_wdata      = dfc_pkg::CELL_START;
        s_ctl        = '{en: 1'b1, we: 1'b1};
        s_addr       = '0;
        s_wdata      = {CW'(1), CW'(1)};
        count_nxt    = NW'(1);
        done_nxt     = 1'b0;
        head_row_nxt = CW'(1);
        head_col_nxt = CW'(1);
        restart_nxt  = 1'b0;
        res_fire     = 1'b1;
      end
      dfc_pkg::ST_IDLE: begin
        if (start) begin
          case (in_command)
            dfc_pkg::CMD_RESTART: begin
              clr_addr_nxt = '0;
              restart_nxt  = 1'b1;
            end
            dfc_pkg::CMD_STEP: begin
              if (done_r) begin
                res_fire = 1'b1;
              end else begin
                try_nxt   = 2'd0;
                order_nxt = dfc_pkg::ORDER_TABLE[in_order_code];
              end
            end
            dfc_pkg::CMD_READ: begin
              if (read_in) begin
                g_ctl  = '{en: 1'b1, we: 1'b0};
                g_addr = cell_addr(CW'(in_cell_row), CW'(in_cell_col));
              end else begin
                res_fire = 1'b1;
                res_code = dfc_pkg::CELL_WALL;
              end
            end
            default: res_fire = 1'b1;
          endcase
        end
      end
      dfc_pkg::ST_READ: begin
        res_fire = 1'b1;
        res_code = g_rdata;
      end
      dfc_pkg::ST_PROBE: begin
        if (probe_ok) begin
          g_ctl = '{en: 1'b1, we: 1'b0};
        end else if (last_try) begin
          pop_go = 1'b1;
        end else begin
          try_nxt = try_r + 2'd1;
        end
      end
      dfc_pkg::ST_CHECK: begin
        if (g_rdata == dfc_pkg::CELL_WALL) begin
          g_ctl = '{en: 1'b1, we: 1'b1};
          s_ctl = '{en: 1'b1, we: 1'b1};
        end else if (last_try) begin
          pop_go = 1'b1;
        end else begin
          try_nxt = try_r + 2'd1;
        end
      end
      dfc_pkg::ST_CARVE: begin
        g_ctl        = '{en: 1'b1, we: 1'b1};
        g_addr       = cell_addr(mid_row, mid_col);
        count_nxt    = count_r + NW'(1);
        head_row_nxt = tgt_row;
        head_col_nxt = tgt_col;
        res_fire     = 1'b1;
      end
      dfc_pkg::ST_POP: begin
        head_row_nxt = s_rdata[SDW-1:CW];
        head_col_nxt = s_rdata[CW-1:0];
        res_fire     = 1'b1;
      end
      default: begin
        res_fire = 1'b0;
      end
    endcase

    if (pop_go) begin
      count_nxt = count_r - NW'(1);
      if (count_r == NW'(1)) begin
        g_ctl    = '{en: 1'b1, we: 1'b1};
        g_addr   = cell_addr(CW'(h_cl - SW'(2)), CW'(w_cl - SW'(2)));
        g_wdata  = dfc_pkg::CELL_END;
        done_nxt = 1'b1;
        res_fire = 1'b1;
      end else begin
        s_ctl  = '{en: 1'b1, we: 1'b0};
        s_addr = KW'(count_r - NW'(2));
      end
    end

    res_valid_nxt = res_fire;
    res_data_nxt  = res_data_r;
    if (res_fire) begin
      res_data_nxt.valid     = 1'b1;
      res_data_nxt.cell_code = res_code;
      res_data_nxt.carved    = (state_r == dfc_pkg::ST_CARVE);
      res_data_nxt.gen_done  = done_nxt;
      if (count_nxt == '0) begin
        res_data_nxt.head_row = '0;
        res_data_nxt.head_col = '0;
      end else begin
        res_data_nxt.head_row = dfc_pkg::FIELD_W'(head_row_nxt);
        res_data_nxt.head_col = dfc_pkg::FIELD_W'(head_col_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dfc_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      restart_r   <= 1'b0;
      count_r     <= '0;
      done_r      <= 1'b1;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      restart_r   <= restart_nxt;
      count_r     <= count_nxt;
      done_r      <= done_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    try_r      <= try_nxt;
    order_r    <= order_nxt;
    head_row_r <= head_row_nxt;
    head_col_r <= head_col_nxt;
    res_data_r <= res_data_nxt;
  end

  assign busy = (state_r != dfc_pkg::ST_IDLE);

  always_comb begin
    result       = res_data_r;
    result.valid = res_valid_r;
  end

endmodule

/* rtl/core/dfs_maze_carver.sv */
// Depth-first maze carver on a grid of up to MAX_SIDE x MAX_SIDE cells.
// Commands enter on start/in_* and are taken when start is high and busy is
// low: restart, one carving step, or a read of one cell. Each command gives
// one result beat on out_*, marked by out_valid for a single cycle; the
// receiver cannot stall, so results must be taken as they appear.
// Grid sizes are written over the APB port (width at 0x0, height at 0x4)
// while the block is idle; pready is always high.
// Command flow: a step probes and checks each direction tried, in order, and
//   then carves, pops, or marks the end cell once the stack empties; a step
//   after generation ended answers straight from idle. A read inside the grid
//   reads one cell, a read outside it answers straight from idle, and a
//   restart rewrites the whole grid.
// The grid lives in one single-port memory, so neighbor probes and carve
// writes go over that one port one access at a time.
// After reset the block sweeps the whole grid to wall with busy high; it
// then reports generation done with an empty stack until the first
// restart.
module dfs_maze_carver #(
  parameter int MAX_SIDE    = 64,
  parameter int STACK_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [4:0]  in_order_code,
  input  logic [5:0]  in_cell_row,
  input  logic [5:0]  in_cell_col,
  output logic        out_valid,
  output logic [1:0]  out_cell_code,
  output logic        out_carved,
  output logic        out_generation_done,
  output logic [5:0]  out_head_row,
  output logic [5:0]  out_head_col,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [dfc_pkg::SIZE_W-1:0] grid_width_r, grid_height_r;
  logic                       cfg_wr;
  dfc_pkg::result_t           result;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= dfc_pkg::SIZE_RESET;
      grid_height_r <= dfc_pkg::SIZE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        dfc_pkg::REG_IDX_WIDTH:  grid_width_r  <= pwdata[dfc_pkg::SIZE_W-1:0];
        dfc_pkg::REG_IDX_HEIGHT: grid_height_r <= pwdata[dfc_pkg::SIZE_W-1:0];
        default:                 grid_width_r  <= grid_width_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      dfc_pkg::REG_IDX_WIDTH:  prdata = 32'(grid_width_r);
      dfc_pkg::REG_IDX_HEIGHT: prdata = 32'(grid_height_r);
      default:                 prdata = '0;
    endcase
  end

  dfc_ctrl #(.MAX_SIDE(MAX_SIDE), .STACK_DEPTH(STACK_DEPTH)) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_command    (in_command),
    .in_order_code (in_order_code),
    .in_cell_row   (in_cell_row),
    .in_cell_col   (in_cell_col),
    .grid_width    (grid_width_r),
    .grid_height   (grid_height_r),
    .result        (result)
  );

  assign out_valid           = result.valid;
  assign out_cell_code       = result.cell_code;
  assign out_carved          = result.carved;
  assign out_generation_done = result.gen_done;
  assign out_head_row        = result.head_row;
  assign out_head_col        = result.head_col;

endmodule

/* rtl/core/dfc_chk.sv */
module dfc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic        out_carved,
  input logic        out_generation_done,
  input logic [5:0]  out_head_row,
  input logic [5:0]  out_head_col
);

  // an accepted command either keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted command neither busy nor answered");

  a_carve_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_carved) |-> !out_generation_done)
    else $error("carve reported after generation ended");

  a_done_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_generation_done) |-> (out_head_row == 6'd0 && out_head_col == 6'd0))
    else $error("head not cleared once generation ended");

  // stack entries always sit on odd coordinates
  a_head_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_generation_done) |-> (out_head_row[0] && out_head_col[0]))
    else $error("stack head on even coordinate");

endmodule

bind dfs_maze_carver dfc_chk u_dfc_chk (.*);
